// ===== sv/insertion_indexed_linked_list_assert.svh =====
// Assertion macros for the insertion-indexed linked list.
`ifndef INSERTION_INDEXED_LINKED_LIST_ASSERT_SVH
`define INSERTION_INDEXED_LINKED_LIST_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define IILL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define IILL_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property in the following cycle.
`define IILL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/iill_pkg.sv =====
// Types, codes and constants shared by the linked-list modules.
`timescale 1ns / 1ps
package iill_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned MAX_WALK     = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned VAL_W        = 32;

  typedef enum logic [1:0] {
    CMD_INS_HEAD  = 2'd0,
    CMD_INS_AFTER = 2'd1,
    CMD_DEL_AFTER = 2'd2,
    CMD_WALK      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } stat_e;

  typedef struct packed {
    cmd_e                    command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    stat_e                   status;
    logic signed [VAL_W-1:0] item_value;
    logic                    list_empty;
    logic                    last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic go;
    logic link;
    logic unlink;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic more_link;
    logic more_del;
    logic walk_more;
  } chk_t;

endpackage

// ===== sv/iill_dp.sv =====
// Datapath: node pool memories, head and fill registers, command decode and result register.
`timescale 1ns / 1ps
module iill_dp import iill_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  ctl_t ctl_i,
  output chk_t chk_o,
  output out_t out_data_o
);

  localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW       = $clog2(CAPACITY + 1);
  localparam int unsigned XW       = AW + POS_W;
  localparam int unsigned KW       = IW + POS_W;
  localparam int unsigned WALK_MAX = (CAPACITY < MAX_WALK) ? CAPACITY : MAX_WALK;
  localparam int unsigned CW       = (WALK_MAX > 1) ? $clog2(WALK_MAX) : 1;

  logic [IW-1:0]    next_mem  [CAPACITY];
  logic [VAL_W-1:0] value_mem [CAPACITY];
  logic             live_mem  [CAPACITY];

  cmd_e             cmd_q;
  logic [POS_W-1:0] k_q;
  logic [VAL_W-1:0] val_q;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    used_q, used_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    nxt_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic             live_rd_q;
  out_t             out_q;

  logic [IW-1:0] head_m1, nxt_m1;
  logic [XW-1:0] pos_m1, k_m1;
  logic          full, k_zero, k_ok, head_zero, nxt_zero, walk_last;
  stat_e         stat;
  logic          ins_go, del_go;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          nw_en, vw_en, lw_en, lw_data;
  logic [AW-1:0] nw_addr, lw_addr;
  logic [IW-1:0] nw_data;

  assign head_m1   = head_q - IW'(1);
  assign nxt_m1    = nxt_rd_q - IW'(1);
  assign pos_m1    = XW'(in_data_i.position) - XW'(1);
  assign k_m1      = XW'(k_q) - XW'(1);
  assign full      = (used_q == IW'(CAPACITY));
  assign k_zero    = (k_q == '0);
  assign k_ok      = !k_zero && (KW'(k_q) <= KW'(used_q)) && live_rd_q;
  assign head_zero = (head_q == '0);
  assign nxt_zero  = (nxt_rd_q == '0);
  assign walk_last = head_zero || nxt_zero || (cnt_q == CW'(WALK_MAX - 1));

  always_comb begin
    stat  = ST_DONE;
    chk_o = '0;
    case (cmd_q)
      CMD_INS_HEAD: begin
        if (full) stat = ST_FULL;
      end
      CMD_INS_AFTER: begin
        if (!k_ok) begin
          stat = ST_IGNORED;
        end else if (full) begin
          stat = ST_FULL;
        end else begin
          chk_o.more_link = 1'b1;
        end
      end
      CMD_DEL_AFTER: begin
        if (k_zero) begin
          if (head_zero) stat = ST_IGNORED;
        end else if (!k_ok || nxt_zero) begin
          stat = ST_IGNORED;
        end else begin
          chk_o.more_del = 1'b1;
        end
      end
      CMD_WALK: begin
        chk_o.walk_more = !walk_last;
      end
      default: stat = ST_DONE;
    endcase
  end

  assign ins_go = ctl_i.go && (stat == ST_DONE) &&
                  ((cmd_q == CMD_INS_HEAD) || (cmd_q == CMD_INS_AFTER));
  assign del_go = ctl_i.go && (stat == ST_DONE) && (cmd_q == CMD_DEL_AFTER);

  assign rd_en = ctl_i.accept || ctl_i.go;

  always_comb begin
    if (ctl_i.accept) begin
      if ((in_data_i.command == CMD_WALK) ||
          ((in_data_i.command == CMD_DEL_AFTER) && (in_data_i.position == '0))) begin
        rd_addr = head_m1[AW-1:0];
      end else begin
        rd_addr = pos_m1[AW-1:0];
      end
    end else begin
      rd_addr = nxt_m1[AW-1:0];
    end
  end

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = used_q[AW-1:0];
    nw_data = (cmd_q == CMD_INS_HEAD) ? head_q : nxt_rd_q;
    if (ins_go) begin
      nw_en = 1'b1;
    end else if (ctl_i.link) begin
      nw_en   = 1'b1;
      nw_addr = k_m1[AW-1:0];
      nw_data = used_q;
    end else if (ctl_i.unlink) begin
      nw_en   = 1'b1;
      nw_addr = k_m1[AW-1:0];
      nw_data = nxt_rd_q;
    end
  end

  assign vw_en = ins_go;

  always_comb begin
    lw_en   = ins_go || del_go;
    lw_data = ins_go;
    if (ins_go) begin
      lw_addr = used_q[AW-1:0];
    end else if (k_zero) begin
      lw_addr = head_m1[AW-1:0];
    end else begin
      lw_addr = nxt_m1[AW-1:0];
    end
  end

  always_comb begin
    head_d = head_q;
    used_d = used_q;
    cnt_d  = cnt_q;
    if (ins_go) begin
      used_d = used_q + IW'(1);
      if (cmd_q == CMD_INS_HEAD) head_d = used_q + IW'(1);
    end
    if (del_go && k_zero) head_d = nxt_rd_q;
    if (ctl_i.accept) begin
      cnt_d = '0;
    end else if (ctl_i.go && (cmd_q == CMD_WALK)) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      used_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      used_q <= used_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= in_data_i.command;
      k_q   <= in_data_i.position;
      val_q <= in_data_i.value;
    end
    if (ctl_i.go) begin
      out_q.status     <= stat;
      out_q.item_value <= ((cmd_q == CMD_WALK) && !head_zero) ? val_rd_q : '0;
      out_q.list_empty <= (cmd_q == CMD_WALK) && head_zero;
      out_q.last       <= (cmd_q != CMD_WALK) || walk_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (vw_en) value_mem[used_q[AW-1:0]] <= val_q;
    if (lw_en) live_mem[lw_addr] <= lw_data;
    if (rd_en) begin
      nxt_rd_q  <= next_mem[rd_addr];
      val_rd_q  <= value_mem[rd_addr];
      live_rd_q <= live_mem[rd_addr];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/iill_ctrl.sv =====
// Controller: command sequencing and output beat handshake.
`timescale 1ns / 1ps
module iill_ctrl import iill_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  chk_t chk_i,
  output ctl_t ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_LINK,
    S_UNLINK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctl_o        = '0;
    ctl_o.accept = (state_q == S_IDLE) && in_valid_i;
    ctl_o.go     = (state_q == S_DECIDE) && out_free;
    ctl_o.link   = (state_q == S_LINK);
    ctl_o.unlink = (state_q == S_UNLINK);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (chk_i.more_link) begin
            state_d = S_LINK;
          end else if (chk_i.more_del) begin
            state_d = S_UNLINK;
          end else if (!chk_i.walk_more) begin
            state_d = S_IDLE;
          end
        end
      end
      S_LINK:   state_d = S_IDLE;
      S_UNLINK: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/insertion_indexed_linked_list.sv =====
// Top level of the insertion-indexed linked list: controller, datapath and checks.
`timescale 1ns / 1ps
// Singly linked list kept in a node pool of CAPACITY entries; nodes are named by
// insertion number and numbers are never reused. One command is in work at a time.
// Every command is decoded after it is accepted and gives its first result beat once
// the output is free. Insert at head, delete of the head and any rejected command
// then return to idle; a successful insert after k or delete after a nonzero k first
// passes through a link or unlink state that writes the link on the single write port
// of the next-pointer memory. A walk gives one beat per listed node (at most
// min(CAPACITY, 64) beats), paced by the registered read of the next-pointer memory;
// an empty walk gives a single beat. A beat that still waits at the output holds back
// the next beat until it is taken. A new command is accepted while the last result
// beat still waits at the output. Live marks need no clearing after reset: the fill
// count hides every pool entry that was never allocated.
module insertion_indexed_linked_list import iill_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ctl_t ctl;
  chk_t chk;

  iill_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .chk_i       (chk),
    .ctl_o       (ctl)
  );

  iill_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctl_i      (ctl),
    .chk_o      (chk),
    .out_data_o (out_data_o)
  );

`include "insertion_indexed_linked_list_assert.svh"

  `IILL_ASSERT(a_one_action, $onehot0({ctl.accept, ctl.go, ctl.link, ctl.unlink}),
               "overlapping controller actions")
  `IILL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                    "accepted a beat while busy")
  `IILL_ASSERT_IMP(a_link_after_go, ctl.link || ctl.unlink, $past(ctl.go),
                   "link write without a decided command")
  `IILL_ASSERT_IMP(a_empty_is_last, out_valid_o && out_data_o.list_empty,
                   out_data_o.last && (out_data_o.item_value == '0),
                   "empty walk beat not final")

endmodule
